>>> src/abcd_rts_pkg.sv
package abcd_rts_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC   = 20;
    localparam int OPW    = DATA_W + 1;
    localparam int PRODW  = 2 * OPW;
    localparam int ACCW   = PRODW + 2;
    localparam int CNTW   = 5;

    localparam logic REG_MODE = 1'b0;

    localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC;
    localparam logic signed [OPW-1:0]    TWO_Q = OPW'(1) << (FRAC + 1);

    localparam logic signed [ACCW-1:0] ACC_HALF   = ACCW'(1) << (FRAC - 1);
    localparam logic signed [ACCW-1:0] ACC_HALF_W = ACCW'(1) << (FRAC + 1);
    localparam logic signed [ACCW-1:0] ACC_FOUR   = ACCW'(1) << (2 * FRAC + 2);
    localparam logic signed [ACCW-1:0] SAT_MAX    = (ACCW'(1) << (DATA_W - 1)) - ACCW'(1);
    localparam logic signed [ACCW-1:0] SAT_MIN    = -SAT_MAX - ACCW'(1);

    typedef struct packed {
        logic       vld;
        logic       neg;
        logic       first;
        logic       last;
        logic       stab;
        logic [2:0] dest;
    } mac_op_t;

    typedef struct packed {
        logic       vld;
        logic       stab;
        logic [2:0] dest;
    } mac_res_t;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_MUL     = 7'b0000010,
        S_DRAIN   = 7'b0000100,
        S_SUM     = 7'b0001000,
        S_SQ      = 7'b0010000,
        S_SQDRAIN = 7'b0100000,
        S_OUT     = 7'b1000000
    } state_t;

    function automatic logic signed [DATA_W-1:0] round_sat(
        input logic signed [ACCW-1:0] a,
        input logic                   wide
    );
        logic signed [ACCW-1:0] r;
        if (wide) begin
            r = (a + ACC_HALF_W) >>> (FRAC + 2);
        end else begin
            r = (a + ACC_HALF) >>> FRAC;
        end
        if (r > SAT_MAX) begin
            return SAT_MAX[DATA_W-1:0];
        end else if (r < SAT_MIN) begin
            return SAT_MIN[DATA_W-1:0];
        end
        return r[DATA_W-1:0];
    endfunction

endpackage

>>> src/abcd_rts_mac.sv
module abcd_rts_mac
    import abcd_rts_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mac_op_t                  op,
    input  logic signed [OPW-1:0]    opa,
    input  logic signed [OPW-1:0]    opb,
    output mac_res_t                 res,
    output logic signed [DATA_W-1:0] res_data,
    output logic                     busy
);

    logic signed [PRODW-1:0] prod_reg;
    mac_op_t                 op1_reg;
    mac_res_t                op2_reg;
    logic signed [ACCW-1:0]  acc_reg;
    logic signed [ACCW-1:0]  term;
    logic signed [ACCW-1:0]  base;

    assign term = op1_reg.neg ? -{{2{prod_reg[PRODW-1]}}, prod_reg}
                              :  {{2{prod_reg[PRODW-1]}}, prod_reg};
    assign base = op1_reg.first ? (op1_reg.stab ? ACC_FOUR : '0) : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op1_reg <= '0;
            op2_reg <= '0;
        end else begin
            op1_reg     <= op;
            op2_reg.vld <= op1_reg.vld & op1_reg.last;
            op2_reg.stab <= op1_reg.stab;
            op2_reg.dest <= op1_reg.dest;
        end
        prod_reg <= opa * opb;
        if (op1_reg.vld) begin
            acc_reg <= base + term;
        end
    end

    assign res      = op2_reg;
    assign res_data = round_sat(acc_reg, op2_reg.stab);
    assign busy     = op1_reg.vld | op2_reg.vld;

endmodule

>>> src/abcd_round_trip_stability.sv
// Round-trip product of complex 2x2 ABCD matrices, Q11.20. Each word on the s_
// channel right-multiplies the running product; one shared 33x33 multiplier
// with an accumulator computes the 32 real products; s_ready is low from each
// accepted word until its products have drained, so a new word is taken only
// after the last one is done. A word with last_element set keeps s_ready low
// longer for the stability figure; m_valid rises once that figure is ready and
// the m_ word is held until m_ready, with the product already back at identity.
// stability_mode (address 0) selects Re((A+D)/2) or Re(1-h*h); write it only
// while idle.
module abcd_round_trip_stability
    import abcd_rts_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_a_re,
    input  logic signed [DATA_W-1:0] s_a_im,
    input  logic signed [DATA_W-1:0] s_b_re,
    input  logic signed [DATA_W-1:0] s_b_im,
    input  logic signed [DATA_W-1:0] s_c_re,
    input  logic signed [DATA_W-1:0] s_c_im,
    input  logic signed [DATA_W-1:0] s_d_re,
    input  logic signed [DATA_W-1:0] s_d_im,
    input  logic                     s_last_element,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_prod_a_re,
    output logic signed [DATA_W-1:0] m_prod_a_im,
    output logic signed [DATA_W-1:0] m_prod_b_re,
    output logic signed [DATA_W-1:0] m_prod_b_im,
    output logic signed [DATA_W-1:0] m_prod_c_re,
    output logic signed [DATA_W-1:0] m_prod_c_im,
    output logic signed [DATA_W-1:0] m_prod_d_re,
    output logic signed [DATA_W-1:0] m_prod_d_im,
    output logic signed [DATA_W-1:0] m_stability_value,
    output logic                     m_is_stable
);

    state_t                   state_reg, state_next;
    logic [CNTW-1:0]          cnt_reg;
    logic                     mode_reg;
    logic                     last_reg;
    logic signed [DATA_W-1:0] p_reg [8];
    logic signed [DATA_W-1:0] n_reg [8];
    logic signed [DATA_W-1:0] m_reg [8];
    logic signed [OPW-1:0]    sum_s_reg, sum_t_reg;
    logic signed [DATA_W-1:0] stab_reg;
    logic signed [OPW-1:0]    half_tr;

    mac_op_t                  op;
    logic signed [OPW-1:0]    opa, opb;
    mac_res_t                 res;
    logic signed [DATA_W-1:0] res_data;
    logic                     mac_busy;

    logic [1:0] q;
    logic [1:0] t;
    logic       im;
    logic [2:0] pi;
    logic [2:0] mj;

    assign pready = 1'b1;
    assign prdata = {31'b0, mode_reg};

    assign q  = cnt_reg[4:3];
    assign im = cnt_reg[2];
    assign t  = cnt_reg[1:0];
    assign pi = {q[1], t[1], t[0]};
    assign mj = {t[1], q[0], im ? ~t[0] : t[0]};

    always_comb begin
        op  = '0;
        opa = '0;
        opb = '0;
        unique case (state_reg)
            S_MUL: begin
                op.vld   = 1'b1;
                op.neg   = ~im & t[0];
                op.first = (t == 2'd0);
                op.last  = (t == 2'd3);
                op.dest  = cnt_reg[4:2];
                opa      = {p_reg[pi][DATA_W-1], p_reg[pi]};
                opb      = {m_reg[mj][DATA_W-1], m_reg[mj]};
            end
            S_SQ: begin
                op.vld   = 1'b1;
                op.stab  = 1'b1;
                op.neg   = ~cnt_reg[0];
                op.first = ~cnt_reg[0];
                op.last  = cnt_reg[0];
                opa      = cnt_reg[0] ? sum_t_reg : sum_s_reg;
                opb      = cnt_reg[0] ? sum_t_reg : sum_s_reg;
            end
            default: begin
                op = '0;
            end
        endcase
    end

    abcd_rts_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .opa      (opa),
        .opb      (opb),
        .res      (res),
        .res_data (res_data),
        .busy     (mac_busy)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_valid) state_next = S_MUL;
            S_MUL:     if (cnt_reg == '1) state_next = S_DRAIN;
            S_DRAIN:   if (!mac_busy) state_next = last_reg ? S_SUM : S_IDLE;
            S_SUM:     state_next = S_SQ;
            S_SQ:      if (cnt_reg[0]) state_next = S_SQDRAIN;
            S_SQDRAIN: if (!mac_busy) state_next = S_OUT;
            S_OUT:     if (m_ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    assign half_tr = (sum_s_reg + OPW'(1)) >>> 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            mode_reg  <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                p_reg[i] <= '0;
            end
            p_reg[0] <= ONE_Q;
            p_reg[6] <= ONE_Q;
        end else begin
            state_reg <= state_next;
            if (psel && penable && pwrite && paddr[2] == REG_MODE) begin
                mode_reg <= pwdata[0];
            end
            if (state_next != state_reg) begin
                cnt_reg <= '0;
            end else begin
                cnt_reg <= cnt_reg + CNTW'(1);
            end
            if (state_reg == S_DRAIN && !mac_busy) begin
                if (last_reg) begin
                    for (int i = 0; i < 8; i++) begin
                        p_reg[i] <= '0;
                    end
                    p_reg[0] <= ONE_Q;
                    p_reg[6] <= ONE_Q;
                end else begin
                    for (int i = 0; i < 8; i++) begin
                        p_reg[i] <= n_reg[i];
                    end
                end
            end
        end
        if (state_reg == S_IDLE && s_valid) begin
            m_reg[0] <= s_a_re;
            m_reg[1] <= s_a_im;
            m_reg[2] <= s_b_re;
            m_reg[3] <= s_b_im;
            m_reg[4] <= s_c_re;
            m_reg[5] <= s_c_im;
            m_reg[6] <= s_d_re;
            m_reg[7] <= s_d_im;
            last_reg <= s_last_element;
        end
        if (res.vld && !res.stab) begin
            n_reg[res.dest] <= res_data;
        end
        if (res.vld && res.stab) begin
            stab_reg <= mode_reg ? res_data : half_tr[DATA_W-1:0];
        end
        if (state_reg == S_SUM) begin
            sum_s_reg <= {n_reg[0][DATA_W-1], n_reg[0]} + {n_reg[6][DATA_W-1], n_reg[6]};
            sum_t_reg <= {n_reg[1][DATA_W-1], n_reg[1]} + {n_reg[7][DATA_W-1], n_reg[7]};
        end
    end

    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = (state_reg == S_OUT);
    assign m_prod_a_re       = n_reg[0];
    assign m_prod_a_im       = n_reg[1];
    assign m_prod_b_re       = n_reg[2];
    assign m_prod_b_im       = n_reg[3];
    assign m_prod_c_re       = n_reg[4];
    assign m_prod_c_im       = n_reg[5];
    assign m_prod_d_re       = n_reg[6];
    assign m_prod_d_im       = n_reg[7];
    assign m_stability_value = stab_reg;
    assign m_is_stable       = (sum_s_reg > -TWO_Q) && (sum_s_reg < TWO_Q);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input and result sides active together");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !mac_busy) else $error("shared unit busy while idle");

    a_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (p_reg[0] == ONE_Q && p_reg[1] == '0))
        else $error("product not back to identity after result");

endmodule

>>> verif/abcd_rts_checker.sv
module abcd_rts_checker
    import abcd_rts_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    input  logic                     pready,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_a_re,
    input  logic signed [DATA_W-1:0] s_a_im,
    input  logic signed [DATA_W-1:0] s_b_re,
    input  logic signed [DATA_W-1:0] s_b_im,
    input  logic signed [DATA_W-1:0] s_c_re,
    input  logic signed [DATA_W-1:0] s_c_im,
    input  logic signed [DATA_W-1:0] s_d_re,
    input  logic signed [DATA_W-1:0] s_d_im,
    input  logic                     s_last_element,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [DATA_W-1:0] m_prod_a_re,
    input  logic signed [DATA_W-1:0] m_prod_a_im,
    input  logic signed [DATA_W-1:0] m_prod_b_re,
    input  logic signed [DATA_W-1:0] m_prod_b_im,
    input  logic signed [DATA_W-1:0] m_prod_c_re,
    input  logic signed [DATA_W-1:0] m_prod_c_im,
    input  logic signed [DATA_W-1:0] m_prod_d_re,
    input  logic signed [DATA_W-1:0] m_prod_d_im,
    input  logic signed [DATA_W-1:0] m_stability_value,
    input  logic                     m_is_stable,
    output int                       fail_count,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WW = 96;
    localparam logic [2:0] ADDR_MODE = 3'd0;

    typedef logic signed [DATA_W-1:0] q_t;
    typedef logic signed [WW-1:0]     w_t;

    typedef struct {
        q_t   prod [8];
        q_t   stab;
        logic stable;
    } trip_result_t;

    q_t           running_prod [8];
    logic         mode_sq;
    trip_result_t trip_results [$];

    assign pending = trip_results.size();

    function automatic w_t wmul(input q_t x, input q_t y);
        w_t a;
        w_t b;
        a = x;
        b = y;
        return a * b;
    endfunction

    function automatic q_t rnd_sat(input w_t a, input int n);
        w_t r;
        w_t hi;
        w_t lo;
        hi = (w_t'(1) <<< (DATA_W - 1)) - 1;
        lo = -hi - 1;
        r = (a + (w_t'(1) <<< (n - 1))) >>> n;
        if (r > hi) return hi[DATA_W-1:0];
        if (r < lo) return lo[DATA_W-1:0];
        return r[DATA_W-1:0];
    endfunction

    task automatic mat_entry(input q_t p [8], input q_t m [8], input int i1, input int j1,
                             input int i2, input int j2, output q_t re, output q_t im);
        w_t r;
        w_t s;
        r = wmul(p[i1], m[j1]) - wmul(p[i1+1], m[j1+1])
          + wmul(p[i2], m[j2]) - wmul(p[i2+1], m[j2+1]);
        s = wmul(p[i1], m[j1+1]) + wmul(p[i1+1], m[j1])
          + wmul(p[i2], m[j2+1]) + wmul(p[i2+1], m[j2]);
        re = rnd_sat(r, FRAC);
        im = rnd_sat(s, FRAC);
    endtask

    task automatic load_identity();
        foreach (running_prod[i]) running_prod[i] = '0;
        running_prod[0] = q_t'(1) <<< FRAC;
        running_prod[6] = q_t'(1) <<< FRAC;
    endtask

    task automatic advance_product(input q_t m [8], input logic last);
        q_t           n [8];
        w_t           s;
        w_t           t;
        w_t           two;
        trip_result_t res;
        mat_entry(running_prod, m, 0, 0, 2, 4, n[0], n[1]);
        mat_entry(running_prod, m, 0, 2, 2, 6, n[2], n[3]);
        mat_entry(running_prod, m, 4, 0, 6, 4, n[4], n[5]);
        mat_entry(running_prod, m, 4, 2, 6, 6, n[6], n[7]);
        running_prod = n;
        if (last) begin
            s = w_t'(n[0]) + w_t'(n[6]);
            t = w_t'(n[1]) + w_t'(n[7]);
            two = w_t'(1) <<< (FRAC + 1);
            if (!mode_sq) begin
                res.stab = q_t'((s + 1) >>> 1);
            end else begin
                res.stab = rnd_sat((w_t'(1) <<< (2 * FRAC + 2)) - s * s + t * t, FRAC + 2);
            end
            res.prod = n;
            res.stable = (s > -two) && (s < two);
            trip_results.insert(trip_results.size(), res);
            load_identity();
        end
    endtask

    task automatic cmp(input string name, input q_t exp_v, input q_t act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        mode_sq = 1'b0;
        load_identity();
    end

    always @(posedge aclk) begin
        q_t           m [8];
        q_t           act [8];
        trip_result_t e;
        if (!aresetn) begin
            mode_sq <= 1'b0;
            load_identity();
            trip_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_MODE) begin
                mode_sq <= pwdata[0];
            end
            if (m_valid && m_ready) begin
                if (trip_results.size() == 0) begin
                    $error("unexpected result word");
                    fail_count++;
                end else begin
                    e = trip_results.pop_front();
                    act = '{m_prod_a_re, m_prod_a_im, m_prod_b_re, m_prod_b_im,
                            m_prod_c_re, m_prod_c_im, m_prod_d_re, m_prod_d_im};
                    cmp("prod_a_re", e.prod[0], act[0]);
                    cmp("prod_a_im", e.prod[1], act[1]);
                    cmp("prod_b_re", e.prod[2], act[2]);
                    cmp("prod_b_im", e.prod[3], act[3]);
                    cmp("prod_c_re", e.prod[4], act[4]);
                    cmp("prod_c_im", e.prod[5], act[5]);
                    cmp("prod_d_re", e.prod[6], act[6]);
                    cmp("prod_d_im", e.prod[7], act[7]);
                    cmp("stability_value", e.stab, m_stability_value);
                    if (e.stable !== m_is_stable) begin
                        $error("is_stable: expected %0d, got %0d", e.stable, m_is_stable);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                m = '{s_a_re, s_a_im, s_b_re, s_b_im, s_c_re, s_c_im, s_d_re, s_d_im};
                advance_product(m, s_last_element);
            end
        end
    end

endmodule

>>> verif/abcd_round_trip_stability_tb.sv
module abcd_round_trip_stability_tb;
    import abcd_rts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  TRIP_ITEMS  = 1950;
    localparam int  SETTLE      = 80;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [2:0] ADDR_MODE  = 3'd0;
    localparam logic [2:0] ADDR_SPARE = 3'd4;
    localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC;
    localparam logic signed [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'h8000_0000;

    typedef logic signed [DATA_W-1:0] q_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0, s_ready;
    q_t s_a_re = '0, s_a_im = '0, s_b_re = '0, s_b_im = '0;
    q_t s_c_re = '0, s_c_im = '0, s_d_re = '0, s_d_im = '0;
    logic s_last_element = 1'b0;
    logic m_valid, m_ready = 1'b0;
    q_t m_prod_a_re, m_prod_a_im, m_prod_b_re, m_prod_b_im;
    q_t m_prod_c_re, m_prod_c_im, m_prod_d_re, m_prod_d_im;
    q_t m_stability_value;
    logic m_is_stable;

    int fail_count, pending;
    int tx_idle_pct = 0, rx_idle_pct = 0;
    int sent = 0;
    longint cycles = 0;

    abcd_round_trip_stability dut (.*);
    abcd_rts_checker chk (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_word(input q_t m [8], input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_a_re, s_a_im, s_b_re, s_b_im} <= {m[0], m[1], m[2], m[3]};
        {s_c_re, s_c_im, s_d_re, s_d_im} <= {m[4], m[5], m[6], m[7]};
        s_last_element <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic q_t rand_field(input logic wild);
        int pick;
        pick = $urandom_range(0, 99);
        if (wild || pick < 12) return q_t'($urandom);
        if (pick < 18) return ($urandom_range(0, 1)) ? Q_MAX : Q_MIN;
        if (pick < 45) return Q_ONE + q_t'($urandom_range(0, 4096)) - 2048;
        if (pick < 55) return '0;
        return q_t'($urandom_range(0, 1 << 22)) - (1 << 21);
    endfunction

    task automatic random_trip();
        q_t   m [8];
        int   len;
        logic wild;
        wild = ($urandom_range(0, 99) < 8);
        len = wild ? $urandom_range(1, 6) : $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
            foreach (m[i]) m[i] = rand_field(wild);
            send_word(m, (k == len - 1) || (wild && $urandom_range(0, 9) == 0));
        end
        if (wild) begin
            foreach (m[i]) m[i] = rand_field(1'b0);
            send_word(m, 1'b1);
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (sent < count) random_trip();
        drain();
    endtask

    initial begin
        q_t m [8];
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        m = '{Q_ONE, 0, 0, 0, 0, 0, Q_ONE, 0};
        send_word(m, 1'b1);
        m = '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX};
        send_word(m, 1'b1);
        m = '{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN};
        send_word(m, 1'b1);
        m = '{Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX};
        send_word(m, 1'b0);
        send_word(m, 1'b1);
        m = '{Q_ONE - 1, 0, 0, 0, 0, 0, Q_ONE, 0};
        send_word(m, 1'b1);
        m = '{-Q_ONE, 0, 0, 0, 0, 0, -Q_ONE, 0};
        send_word(m, 1'b1);
        m = '{-Q_ONE + 1, 3, 0, 0, 0, 0, -Q_ONE, -3};
        send_word(m, 1'b1);
        m = '{0, Q_ONE, Q_ONE, 0, 0, 0, 0, Q_ONE};
        send_word(m, 1'b0);
        send_word(m, 1'b0);
        send_word(m, 1'b1);
        m = '{1, -1, 1, -1, 1, -1, 1, -1};
        send_word(m, 1'b1);
        drain();

        apb_write(ADDR_SPARE, 32'h0000_0001);
        apb_write(ADDR_MODE, 32'hFFFF_FFFF);
        m = '{Q_ONE, 0, 0, 0, 0, 0, Q_ONE, 0};
        send_word(m, 1'b1);
        m = '{Q_MAX, Q_MAX, 0, 0, 0, 0, Q_MAX, Q_MIN};
        send_word(m, 1'b1);
        m = '{0, Q_MAX, 0, 0, 0, 0, 0, Q_MAX};
        send_word(m, 1'b1);
        m = '{0, 0, Q_ONE, 0, -Q_ONE, 0, 0, 0};
        send_word(m, 1'b1);
        drain();

        run_phase(30, 74, TRIP_ITEMS / 3);
        apb_write(ADDR_MODE, 32'hFFFF_FFFE);
        run_phase(74, 30, 2 * TRIP_ITEMS / 3);
        apb_write(ADDR_MODE, 32'h0000_0001);
        run_phase(0, 0, 5 * TRIP_ITEMS / 6);
        apb_write(ADDR_MODE, 32'h8000_0000);
        run_phase(0, 0, TRIP_ITEMS);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
